FILE: rtl/wibu_pkg.sv
package wibu_pkg;

	localparam int WORD_W   = 64;
	localparam int WORD_SH  = 6;
	localparam int UNIT_W   = 10;
	localparam int INDEX_W  = 4;
	localparam int DIGIT_W  = 6;
	localparam int WC_W     = 3;

	localparam logic [WC_W-1:0]   WC_RESET = 3'd2;
	localparam logic [UNIT_W:0]   DIVISOR  = 11'd1000;
	localparam logic [UNIT_W-1:0] TEN      = 10'd10;
	localparam logic [UNIT_W-1:0] HUNDRED  = 10'd100;

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_NEG   = 6'b000010,
		S_CHECK = 6'b000100,
		S_DIV   = 6'b001000,
		S_TRIM  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic load_first;
		logic neg_step;
		logic div_start;
		logic div_step;
	} cmd_t;

	typedef struct packed {
		logic              zero;
		logic [UNIT_W-1:0] rem_next;
	} status_t;

	typedef struct packed {
		logic [UNIT_W-1:0]  unit_value;
		logic [INDEX_W-1:0] unit_index;
		logic [DIGIT_W-1:0] digit_count;
		logic               negative;
		logic               overflow;
		logic               last;
	} out_item_t;

endpackage

FILE: rtl/wibu_if.sv
interface wibu_in_if;
	logic                       valid;
	logic                       ready;
	logic [wibu_pkg::WORD_W-1:0] word;

	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

interface wibu_out_if;
	logic                        valid;
	logic                        ready;
	logic [wibu_pkg::UNIT_W-1:0]  unit_value;
	logic [wibu_pkg::INDEX_W-1:0] unit_index;
	logic [wibu_pkg::DIGIT_W-1:0] digit_count;
	logic                        negative;
	logic                        overflow;
	logic                        last;

	modport source (output valid, output unit_value, output unit_index, output digit_count,
		output negative, output overflow, output last, input ready);
	modport sink   (input valid, input unit_value, input unit_index, input digit_count,
		input negative, input overflow, input last, output ready);
endinterface

interface wibu_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [wibu_pkg::WC_W-1:0] word_count;

	modport source (output valid, output word_count, input ready);
	modport sink   (input valid, input word_count, output ready);
endinterface

FILE: rtl/wibu_datapath.sv
module wibu_datapath #(
	parameter int MAX_WORDS = 4
) (
	input  logic                                            clk,
	input  wibu_pkg::cmd_t                                  cmd,
	input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] load_idx,
	input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] n_m1,
	input  logic [wibu_pkg::WORD_W-1:0]                     word,
	output wibu_pkg::status_t                               status
);

	localparam int W     = MAX_WORDS * wibu_pkg::WORD_W;
	localparam int WI_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int BIT_W = $clog2(W);
	localparam int RS_W  = wibu_pkg::UNIT_W + 1;

	logic [W-1:0]                   mag_q;
	logic [wibu_pkg::UNIT_W-1:0]    rem_q;
	logic                           carry_q;

	logic [W-1:0]                   mask;
	logic [BIT_W-1:0]               top_idx;
	logic [RS_W-1:0]                rem_sh;
	logic                           ge;
	logic [wibu_pkg::WORD_W:0]      sum;
	logic [W+wibu_pkg::WORD_W-1:0]  rot_ext;
	logic [W-1:0]                   rot;

	// keep only the words in use
	always_comb begin
		for (int i = 0; i < MAX_WORDS; i++) begin
			mask[i*wibu_pkg::WORD_W +: wibu_pkg::WORD_W] =
				(WI_W'(i) <= n_m1) ? {wibu_pkg::WORD_W{1'b1}} : '0;
		end
	end

	assign top_idx = BIT_W'({n_m1, {wibu_pkg::WORD_SH{1'b1}}});

	// restoring divide step: one quotient bit per cycle
	assign rem_sh = {rem_q, mag_q[top_idx]};
	assign ge     = (rem_sh >= wibu_pkg::DIVISOR);
	assign status.rem_next = ge ? wibu_pkg::UNIT_W'(rem_sh - wibu_pkg::DIVISOR)
	                            : rem_sh[wibu_pkg::UNIT_W-1:0];
	// words above the active count may hold junk after a negation
	assign status.zero = ~|(mag_q & mask);

	// negate one word per cycle, rotating the whole value down by a word;
	// after MAX_WORDS steps every word is back in place
	assign sum     = {1'b0, ~mag_q[wibu_pkg::WORD_W-1:0]} + (wibu_pkg::WORD_W+1)'(carry_q);
	assign rot_ext = {sum[wibu_pkg::WORD_W-1:0], mag_q};
	assign rot     = rot_ext[W+wibu_pkg::WORD_W-1:wibu_pkg::WORD_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			carry_q <= 1'b1;
			if (cmd.load_first) begin
				mag_q <= W'(word);
			end else begin
				for (int i = 0; i < MAX_WORDS; i++) begin
					if (WI_W'(i) == load_idx) begin
						mag_q[i*wibu_pkg::WORD_W +: wibu_pkg::WORD_W] <= word;
					end
				end
			end
		end else if (cmd.neg_step) begin
			mag_q   <= rot;
			carry_q <= sum[wibu_pkg::WORD_W];
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[W-2:0], ge} & mask;
			rem_q <= status.rem_next;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
		end
	end

endmodule

FILE: rtl/wibu_ctrl.sv
module wibu_ctrl #(
	parameter int MAX_WORDS  = 4,
	parameter int UNIT_COUNT = 13,
	parameter int MAX_DIGITS = 38
) (
	input  logic              clk,
	input  logic              arst_n,
	wibu_in_if.sink           words,
	wibu_out_if.source        units,
	wibu_cfg_if.sink          cfg,
	output wibu_pkg::cmd_t    cmd,
	output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] load_idx,
	output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] n_m1,
	input  wibu_pkg::status_t status
);

	localparam int WI_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int BIT_W = $clog2(MAX_WORDS * wibu_pkg::WORD_W);
	localparam int UC_W  = $clog2(UNIT_COUNT + 1);
	localparam int UI_W  = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
	localparam int DG_W  = $clog2(3 * UNIT_COUNT + 1);

	wibu_pkg::state_t             state_q, state_d;
	logic [wibu_pkg::WC_W-1:0]    wc_q;
	logic [wibu_pkg::WC_W-1:0]    wl_q;
	logic [wibu_pkg::WC_W-1:0]    eff;
	logic                         sign_q;
	logic [UC_W-1:0]              units_q;
	logic [UC_W-1:0]              emit_idx_q;
	logic [BIT_W-1:0]             bit_cnt_q;
	logic [WI_W-1:0]              neg_cnt_q;
	logic [wibu_pkg::UNIT_W-1:0]  unit_store_q [UNIT_COUNT];
	logic [wibu_pkg::UNIT_W-1:0]  top_q;
	logic [DG_W-1:0]              digits_q;
	logic                         out_valid_q;
	wibu_pkg::out_item_t          out_q;

	logic                         last_word;
	logic                         out_free;
	logic                         out_load;
	logic                         clear_sign;
	logic                         emit_last;
	logic [DG_W-1:0]              units_x;
	logic [DG_W-1:0]              adj;
	logic [DG_W-1:0]              digits_w;
	wibu_pkg::out_item_t          item_d;

	always_comb begin
		if (wc_q == '0) begin
			eff = wibu_pkg::WC_W'(1);
		end else if (int'(wc_q) > MAX_WORDS) begin
			eff = wibu_pkg::WC_W'(MAX_WORDS);
		end else begin
			eff = wc_q;
		end
	end

	assign n_m1      = WI_W'(eff - wibu_pkg::WC_W'(1));
	assign load_idx  = WI_W'(wl_q);
	assign last_word = (wibu_pkg::WC_W'(wl_q + wibu_pkg::WC_W'(1)) == eff);
	assign out_free  = !out_valid_q || units.ready;
	assign emit_last = (UC_W'(emit_idx_q + UC_W'(1)) == units_q);

	// leading zeros of the top unit come off the digit count
	assign units_x  = DG_W'(units_q);
	assign adj      = (top_q < wibu_pkg::TEN) ? DG_W'(2) :
	                  (top_q < wibu_pkg::HUNDRED) ? DG_W'(1) : DG_W'(0);
	assign digits_w = (units_x << 1) + units_x - adj;

	assign words.ready = (state_q == wibu_pkg::S_LOAD);
	assign cfg.ready   = (state_q == wibu_pkg::S_LOAD);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		out_load   = 1'b0;
		clear_sign = 1'b0;
		item_d     = '0;
		item_d.last = 1'b1;
		unique case (state_q)
			wibu_pkg::S_LOAD: begin
				if (words.valid) begin
					cmd.load       = 1'b1;
					cmd.load_first = (wl_q == '0);
					if (last_word) begin
						state_d = words.word[wibu_pkg::WORD_W-1] ? wibu_pkg::S_NEG
						                                         : wibu_pkg::S_CHECK;
					end
				end
			end
			wibu_pkg::S_NEG: begin
				cmd.neg_step = 1'b1;
				if (neg_cnt_q == WI_W'(MAX_WORDS - 1)) begin
					state_d = wibu_pkg::S_CHECK;
				end
			end
			wibu_pkg::S_CHECK: begin
				if (status.zero) begin
					if (units_q == '0) begin
						// value zero: a single unit with one digit
						item_d.digit_count = wibu_pkg::DIGIT_W'(1);
						if (out_free) begin
							out_load   = 1'b1;
							clear_sign = 1'b1;
							state_d    = wibu_pkg::S_LOAD;
						end
					end else begin
						state_d = wibu_pkg::S_TRIM;
					end
				end else if (int'(units_q) >= UNIT_COUNT) begin
					item_d.negative = sign_q;
					item_d.overflow = 1'b1;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = wibu_pkg::S_LOAD;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = wibu_pkg::S_DIV;
				end
			end
			wibu_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = wibu_pkg::S_CHECK;
				end
			end
			wibu_pkg::S_TRIM: begin
				if (int'(digits_w) > MAX_DIGITS) begin
					item_d.negative = sign_q;
					item_d.overflow = 1'b1;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = wibu_pkg::S_LOAD;
					end
				end else begin
					state_d = wibu_pkg::S_EMIT;
				end
			end
			wibu_pkg::S_EMIT: begin
				item_d.unit_index  = wibu_pkg::INDEX_W'(emit_idx_q);
				item_d.digit_count = wibu_pkg::DIGIT_W'(digits_q);
				item_d.negative    = sign_q;
				item_d.last        = emit_last;
				if (out_free) begin
					out_load = 1'b1;
					if (emit_last) begin
						state_d = wibu_pkg::S_LOAD;
					end
				end
			end
			default: begin
				state_d = wibu_pkg::S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wibu_pkg::S_LOAD;
			wc_q        <= wibu_pkg::WC_RESET;
			wl_q        <= '0;
			sign_q      <= 1'b0;
			units_q     <= '0;
			emit_idx_q  <= '0;
			bit_cnt_q   <= '0;
			neg_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				wc_q <= cfg.word_count;
				wl_q <= '0;
			end else if (cmd.load) begin
				wl_q <= last_word ? '0 : wibu_pkg::WC_W'(wl_q + wibu_pkg::WC_W'(1));
			end
			if (cmd.load && last_word) begin
				sign_q    <= words.word[wibu_pkg::WORD_W-1];
				units_q   <= '0;
				neg_cnt_q <= '0;
			end
			if (clear_sign) begin
				sign_q <= 1'b0;
			end
			if (cmd.neg_step) begin
				neg_cnt_q <= WI_W'(neg_cnt_q + WI_W'(1));
			end
			if (cmd.div_start) begin
				bit_cnt_q <= BIT_W'({n_m1, {wibu_pkg::WORD_SH{1'b1}}});
			end else if (cmd.div_step) begin
				bit_cnt_q <= BIT_W'(bit_cnt_q - BIT_W'(1));
				if (bit_cnt_q == '0) begin
					units_q <= UC_W'(units_q + UC_W'(1));
				end
			end
			if (state_q == wibu_pkg::S_TRIM) begin
				emit_idx_q <= '0;
			end else if (state_q == wibu_pkg::S_EMIT && out_load) begin
				emit_idx_q <= UC_W'(emit_idx_q + UC_W'(1));
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (units.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && bit_cnt_q == '0) begin
			unit_store_q[units_q[UI_W-1:0]] <= status.rem_next;
			top_q                           <= status.rem_next;
		end
		if (state_q == wibu_pkg::S_TRIM) begin
			digits_q <= digits_w;
		end
		if (out_load) begin
			out_q.unit_value  <= (state_q == wibu_pkg::S_EMIT)
			                     ? unit_store_q[emit_idx_q[UI_W-1:0]] : '0;
			out_q.unit_index  <= item_d.unit_index;
			out_q.digit_count <= item_d.digit_count;
			out_q.negative    <= item_d.negative;
			out_q.overflow    <= item_d.overflow;
			out_q.last        <= item_d.last;
		end
	end

	assign units.valid       = out_valid_q;
	assign units.unit_value  = out_q.unit_value;
	assign units.unit_index  = out_q.unit_index;
	assign units.digit_count = out_q.digit_count;
	assign units.negative    = out_q.negative;
	assign units.overflow    = out_q.overflow;
	assign units.last        = out_q.last;

endmodule

FILE: rtl/wide_int_to_base1000_units_top.sv
// Converts a signed two's-complement integer of word_count 64-bit words (lowest word first on
// the words channel) into base-1000 units, least significant first, one result transfer per
// unit with the digit count and sign; a zero value gives one unit 0 with one digit, and a value
// needing more than UNIT_COUNT units or MAX_DIGITS digits gives a single overflow result.
// Words are taken one per cycle while the block is in its load state. After the last word a
// negative value goes through a word-serial negation of all MAX_WORDS words, then each unit
// costs one restoring divide-by-1000 pass over 64 bits per active word plus a check, through the
// single shared compare-subtract unit, followed by a final check, the digit count step and the
// emission of each unit, which waits on output back-pressure. No new word is taken meanwhile.
// The output register lets the next integer start loading while the final result waits.
module wide_int_to_base1000_units_top #(
	parameter int MAX_WORDS  = 4,
	parameter int UNIT_COUNT = 13,
	parameter int MAX_DIGITS = 38
) (
	input  logic       clk,
	input  logic       arst_n,
	wibu_in_if.sink    words,
	wibu_out_if.source units,
	wibu_cfg_if.sink   cfg
);

	localparam int WI_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	wibu_pkg::cmd_t    cmd;
	wibu_pkg::status_t status;
	logic [WI_W-1:0]   load_idx;
	logic [WI_W-1:0]   n_m1;

	wibu_ctrl #(
		.MAX_WORDS  (MAX_WORDS),
		.UNIT_COUNT (UNIT_COUNT),
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (words),
		.units    (units),
		.cfg      (cfg),
		.cmd      (cmd),
		.load_idx (load_idx),
		.n_m1     (n_m1),
		.status   (status)
	);

	wibu_datapath #(
		.MAX_WORDS (MAX_WORDS)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.load_idx (load_idx),
		.n_m1     (n_m1),
		.word     (words.word),
		.status   (status)
	);

`ifndef SYNTHESIS
	a_ovf_single: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && units.overflow |->
			units.last && units.unit_value == '0 && units.digit_count == '0)
		else $error("overflow result is not a lone zeroed result");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && !units.overflow |->
			units.unit_value < 10'd1000 && units.digit_count != '0)
		else $error("unit out of range or missing digit count");

	a_short_value: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && !units.overflow && units.digit_count <= 6'd3 |->
			units.last && units.unit_index == '0)
		else $error("value of up to three digits spans more than one unit");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !words.ready)
		else $error("input ready while a division runs");
`endif

endmodule

FILE: dv/base1000_checker.sv
module base1000_checker #(
	parameter int MAX_WORDS  = 4,
	parameter int UNIT_COUNT = 13,
	parameter int MAX_DIGITS = 38
) (
	input  logic clk,
	input  logic arst_n,
	wibu_in_if   word_bus,
	wibu_out_if  unit_bus,
	wibu_cfg_if  cfg_bus,
	output int   mismatches,
	output int   backlog,
	output int   results_checked,
	output int   overflows_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VAL_W = MAX_WORDS * wibu_pkg::WORD_W;

	logic [wibu_pkg::WC_W-1:0]   wc_shadow;
	logic [wibu_pkg::WORD_W-1:0] word_buf [MAX_WORDS];
	int                          words_held;
	wibu_pkg::out_item_t         expected_units [$];

	function automatic int active_words(logic [wibu_pkg::WC_W-1:0] wc);
		if (wc == 0) begin
			return 1;
		end
		if (wc > MAX_WORDS) begin
			return MAX_WORDS;
		end
		return int'(wc);
	endfunction

	function automatic void push_unit(logic [wibu_pkg::UNIT_W-1:0] value, int idx, int digits,
		logic neg, logic ovf, logic fin);
		wibu_pkg::out_item_t r;
		r.unit_value  = value;
		r.unit_index  = wibu_pkg::INDEX_W'(idx);
		r.digit_count = wibu_pkg::DIGIT_W'(digits);
		r.negative    = neg;
		r.overflow    = ovf;
		r.last        = fin;
		expected_units.push_back(r);
	endfunction

	// Full integer collected: sign, magnitude, then base-1000 groups, low first.
	function automatic void predict_units(int n);
		logic [VAL_W-1:0]            mask;
		logic [VAL_W-1:0]            mag;
		logic [wibu_pkg::UNIT_W-1:0] unit_vals [VAL_W / 9 + 1];
		logic                        neg;
		int                          units;
		int                          digits;
		mag = '0;
		for (int i = 0; i < n; i++) begin
			mag[i*wibu_pkg::WORD_W +: wibu_pkg::WORD_W] = word_buf[i];
		end
		mask = {VAL_W{1'b1}} >> (wibu_pkg::WORD_W * (MAX_WORDS - n));
		neg = mag[n*wibu_pkg::WORD_W - 1];
		if (neg) begin
			mag = (~mag + 1'b1) & mask;
		end
		if (mag == 0) begin
			push_unit('0, 0, 1, 1'b0, 1'b0, 1'b1);
			return;
		end
		units = 0;
		while (mag != 0) begin
			unit_vals[units] = wibu_pkg::UNIT_W'(mag % wibu_pkg::DIVISOR);
			mag = mag / wibu_pkg::DIVISOR;
			units++;
		end
		if (units > UNIT_COUNT) begin
			push_unit('0, 0, 0, neg, 1'b1, 1'b1);
			return;
		end
		digits = 3 * units;
		if (unit_vals[units-1] < wibu_pkg::TEN) begin
			digits -= 2;
		end else if (unit_vals[units-1] < wibu_pkg::HUNDRED) begin
			digits -= 1;
		end
		if (digits > MAX_DIGITS) begin
			push_unit('0, 0, 0, neg, 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < units; i++) begin
			push_unit(unit_vals[i], i, digits, neg, 1'b0, i == units - 1);
		end
	endfunction

	task automatic report(string what, longint got, longint want);
		mismatches++;
		$display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		wibu_pkg::out_item_t seen;
		wibu_pkg::out_item_t want;
		if (!arst_n) begin
			wc_shadow       = wibu_pkg::WC_RESET;
			words_held      = 0;
			mismatches      = 0;
			results_checked = 0;
			overflows_seen  = 0;
			expected_units.delete();
			backlog         = 0;
		end else begin
			if (unit_bus.valid && unit_bus.ready) begin
				seen.unit_value  = unit_bus.unit_value;
				seen.unit_index  = unit_bus.unit_index;
				seen.digit_count = unit_bus.digit_count;
				seen.negative    = unit_bus.negative;
				seen.overflow    = unit_bus.overflow;
				seen.last        = unit_bus.last;
				results_checked++;
				if (seen.overflow === 1'b1) begin
					overflows_seen++;
				end
				if (expected_units.size() == 0) begin
					report("result transfer with nothing pending, unit_index", seen.unit_index, -1);
				end else begin
					want = expected_units.pop_front();
					if (seen.unit_value !== want.unit_value) begin
						report("unit_value", seen.unit_value, want.unit_value);
					end
					if (seen.unit_index !== want.unit_index) begin
						report("unit_index", seen.unit_index, want.unit_index);
					end
					if (seen.digit_count !== want.digit_count) begin
						report("digit_count", seen.digit_count, want.digit_count);
					end
					if (seen.negative !== want.negative) begin
						report("negative", seen.negative, want.negative);
					end
					if (seen.overflow !== want.overflow) begin
						report("overflow", seen.overflow, want.overflow);
					end
					if (seen.last !== want.last) begin
						report("last", seen.last, want.last);
					end
				end
			end
			if (word_bus.valid && word_bus.ready) begin
				if (words_held >= active_words(wc_shadow)) begin
					words_held = 0;
				end
				word_buf[words_held] = word_bus.word;
				words_held++;
				if (words_held == active_words(wc_shadow)) begin
					words_held = 0;
					predict_units(active_words(wc_shadow));
				end
			end
			// a write drops any partly loaded integer
			if (cfg_bus.valid && cfg_bus.ready) begin
				wc_shadow  = cfg_bus.word_count;
				words_held = 0;
			end
			backlog = expected_units.size();
		end
	end

endmodule

FILE: dv/wide_int_to_base1000_units_top_tb.sv
module wide_int_to_base1000_units_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WORDS     = 4;
	localparam int UNIT_COUNT    = 13;
	localparam int MAX_DIGITS    = 38;
	localparam int VAL_W         = MAX_WORDS * wibu_pkg::WORD_W;
	localparam int QUIET_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 3600;
	localparam int PHASE_WORDS   = 32;

	localparam int                        PHASE_IDLE  [4] = '{0, 52, 0, 30};
	localparam int                        PHASE_STALL [4] = '{0, 0, 52, 30};
	localparam logic [wibu_pkg::WC_W-1:0] PHASE_WC    [4] = '{3'd2, 3'd7, 3'd1, 3'd5};

	typedef logic [VAL_W-1:0] value_t;

	logic   clk = 1'b0;
	logic   arst_n;
	int     idle_pct;
	int     stall_pct;
	int     words_sent;
	int     quiet_cycles;
	int     cur_words;
	int     mismatches;
	int     backlog;
	int     results_checked;
	int     overflows_seen;
	value_t ten_pow_38;

	wibu_in_if  word_bus ();
	wibu_out_if unit_bus ();
	wibu_cfg_if cfg_bus ();

	wide_int_to_base1000_units_top #(
		.MAX_WORDS (MAX_WORDS),
		.UNIT_COUNT(UNIT_COUNT),
		.MAX_DIGITS(MAX_DIGITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.words (word_bus),
		.units (unit_bus),
		.cfg   (cfg_bus)
	);

	base1000_checker #(
		.MAX_WORDS (MAX_WORDS),
		.UNIT_COUNT(UNIT_COUNT),
		.MAX_DIGITS(MAX_DIGITS)
	) unit_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.word_bus       (word_bus),
		.unit_bus       (unit_bus),
		.cfg_bus        (cfg_bus),
		.mismatches     (mismatches),
		.backlog        (backlog),
		.results_checked(results_checked),
		.overflows_seen (overflows_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		unit_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// quiet = no transfer on any channel
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (word_bus.valid && word_bus.ready)
			|| (unit_bus.valid && unit_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("wide_int_to_base1000_units_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic [wibu_pkg::WORD_W-1:0] w);
		while ($urandom_range(0, 99) < idle_pct) begin
			word_bus.valid <= 1'b0;
			@(posedge clk);
		end
		word_bus.valid <= 1'b1;
		word_bus.word  <= w;
		do @(posedge clk); while (word_bus.ready !== 1'b1);
		words_sent++;
	endtask

	task automatic send_value(input value_t v);
		for (int i = 0; i < cur_words; i++) begin
			send_word(v[i*wibu_pkg::WORD_W +: wibu_pkg::WORD_W]);
		end
	endtask

	// hold the sender until every pending unit has been taken
	task automatic drain();
		word_bus.valid <= 1'b0;
		do @(negedge clk); while (backlog != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_word_count(input logic [wibu_pkg::WC_W-1:0] wc);
		cfg_bus.valid      <= 1'b1;
		cfg_bus.word_count <= wc;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		cur_words = (wc == 0) ? 1 : (wc > MAX_WORDS) ? MAX_WORDS : int'(wc);
	endtask

	function automatic value_t random_value();
		value_t v;
		int     len;
		for (int i = 0; i < VAL_W / 32; i++) begin
			v[i*32 +: 32] = $urandom();
		end
		case ($urandom_range(0, 5))
			1: begin
				v = value_t'($urandom_range(0, 999999));
			end
			2: begin
				v = value_t'(0) - value_t'($urandom_range(1, 999999));
			end
			3: begin
				v = $urandom_range(0, 1) ? '0 : '1;
			end
			4: begin
				// short magnitudes keep most conversions under the unit limit
				len = $urandom_range(1, cur_words * wibu_pkg::WORD_W);
				v &= {VAL_W{1'b1}} >> (VAL_W - len);
				if ($urandom_range(0, 1)) begin
					v = value_t'(0) - v;
				end
			end
			5: begin
				v = ten_pow_38 + value_t'($urandom_range(0, 4)) - value_t'(2);
				if ($urandom_range(0, 1)) begin
					v = value_t'(0) - v;
				end
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	initial begin
		int target;
		arst_n             = 1'b0;
		word_bus.valid     = 1'b0;
		word_bus.word      = '0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.word_count = wibu_pkg::WC_RESET;
		idle_pct           = 0;
		stall_pct          = 0;
		words_sent         = 0;
		cur_words          = int'(wibu_pkg::WC_RESET);
		ten_pow_38         = value_t'(1);
		repeat (38) ten_pow_38 = ten_pow_38 * value_t'(10);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// word count still at its reset value
		send_value(value_t'(0) - value_t'(1000));
		drain();
		write_word_count(3'd1);
		send_value('0);
		send_value(value_t'(64'h7fff_ffff_ffff_ffff));
		send_value(value_t'(64'h8000_0000_0000_0000));
		send_value(value_t'(1000));
		drain();
		// 38 digits fit, 39 do not
		write_word_count(3'd2);
		send_value(ten_pow_38 - value_t'(1));
		send_value(ten_pow_38);
		send_value(value_t'(0) - (ten_pow_38 - value_t'(1)));
		drain();
		// too many units, positive and most negative
		write_word_count(3'd4);
		send_value({1'b0, {(VAL_W-1){1'b1}}});
		send_value({1'b1, {(VAL_W-1){1'b0}}});
		drain();
		// partial integer, dropped by the next write; zero word count acts as one
		write_word_count(3'd3);
		send_word({$urandom(), $urandom()});
		send_word({$urandom(), $urandom()});
		drain();
		write_word_count(3'd0);
		send_value(value_t'(999));

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			idle_pct  = PHASE_IDLE[ph];
			stall_pct = PHASE_STALL[ph];
			write_word_count(PHASE_WC[ph]);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				if (cur_words > 1 && $urandom_range(0, 11) == 0) begin
					repeat ($urandom_range(1, cur_words - 1)) send_word({$urandom(), $urandom()});
					drain();
					write_word_count(PHASE_WC[ph]);
				end else begin
					send_value(random_value());
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d input words at word count settings 0, 1, 2, 3, 4, 5 and 7",
			words_sent);
		$display("%0d unit transfers checked (%0d overflow), with sender gaps and output stalls",
			results_checked, overflows_seen);
		if (mismatches == 0 && backlog == 0) begin
			$display("wide_int_to_base1000_units_top: match");
		end else begin
			$display("wide_int_to_base1000_units_top: mismatch");
		end
		$finish;
	end

endmodule
